[rtl/srtf_pkg.sv]
package srtf_pkg;

    // Default sizes handed to the top level
    localparam int MAX_JOBS_DEF  = 16;
    localparam int TIME_BITS_DEF = 16;

    // Fixed field widths of the channels and the configuration port
    localparam int FIELD_IDX_W  = 4;
    localparam int FIELD_TIME_W = 16;
    localparam int JOB_COUNT_W  = 5;
    localparam int NOW_W        = 21;
    localparam int SUM_W        = 25;

    localparam logic [JOB_COUNT_W-1:0] JOB_COUNT_RESET = JOB_COUNT_W'(16);
    localparam logic [NOW_W-1:0]       NOW_MAX         = {NOW_W{1'b1}};
    localparam logic [SUM_W-1:0]       SUM_MAX         = {SUM_W{1'b1}};

    // Command codes
    typedef enum logic
    {
        FUNC_LOAD = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    // Sequencer states
    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE,
        ST_ACCUM,
        ST_FINISH
    } srtf_state_t;

    // Control from the sequencer to the selection unit
    typedef struct packed
    {
        logic clear;
        logic compare;
    } pick_ctrl_t;

endpackage

[rtl/srtf_if.sv]
interface srtf_in_if import srtf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [FIELD_IDX_W-1:0]  job_index;
    logic [FIELD_TIME_W-1:0] job_arrival;
    logic [FIELD_TIME_W-1:0] job_burst;

    modport source
    (
        output valid, func, job_index, job_arrival, job_burst,
        input  ready
    );

    modport sink
    (
        input  valid, func, job_index, job_arrival, job_burst,
        output ready
    );
endinterface

interface srtf_out_if import srtf_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   ran_valid;
    logic [FIELD_IDX_W-1:0] ran_index;
    logic                   finished;
    logic [NOW_W-1:0]       completion_time;
    logic [NOW_W-1:0]       turnaround;
    logic [NOW_W-1:0]       waiting;
    logic                   all_done;
    logic [SUM_W-1:0]       total_waiting;
    logic [SUM_W-1:0]       total_turnaround;

    modport source
    (
        output valid, ran_valid, ran_index, finished, completion_time, turnaround,
               waiting, all_done, total_waiting, total_turnaround,
        input  ready
    );

    modport sink
    (
        input  valid, ran_valid, ran_index, finished, completion_time, turnaround,
               waiting, all_done, total_waiting, total_turnaround,
        output ready
    );
endinterface

[rtl/srtf_job_mem.sv]
module srtf_job_mem import srtf_pkg::*; #(
    parameter int  DEPTH  = MAX_JOBS_DEF,
    parameter int  DATA_W = 3 * TIME_BITS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/srtf_pick.sv]
module srtf_pick import srtf_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int IDX_W     = $clog2(MAX_JOBS_DEF)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pick_ctrl_t           ctrl,
    input  logic [IDX_W-1:0]     rd_idx,
    input  logic                 rd_busy,
    input  logic [TIME_BITS-1:0] rd_arr,
    input  logic [TIME_BITS-1:0] rd_burst,
    input  logic [TIME_BITS-1:0] rd_rem,
    input  logic [NOW_W-1:0]     now,
    output logic                 best_vld,
    output logic [IDX_W-1:0]     best_idx,
    output logic [TIME_BITS-1:0] best_rem,
    output logic [TIME_BITS-1:0] best_arr,
    output logic [TIME_BITS-1:0] best_burst
);

    localparam int CMP_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

    logic                 best_vld_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [TIME_BITS-1:0] best_rem_reg;
    logic [TIME_BITS-1:0] best_arr_reg;
    logic [TIME_BITS-1:0] best_burst_reg;
    logic                 take;

    // Entry is a better candidate: arrived, unfinished, strictly shorter
    assign take = ctrl.compare && rd_busy && (CMP_W'(rd_arr) <= CMP_W'(now)) &&
                  (!best_vld_reg || (rd_rem < best_rem_reg));

    // Track whether any candidate has been seen this tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_vld_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            best_vld_reg <= 1'b0;
        end
        else if (take)
        begin
            best_vld_reg <= 1'b1;
        end
    end

    // Hold the best entry so far
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg   <= rd_idx;
            best_rem_reg   <= rd_rem;
            best_arr_reg   <= rd_arr;
            best_burst_reg <= rd_burst;
        end
    end

    assign best_vld   = best_vld_reg;
    assign best_idx   = best_idx_reg;
    assign best_rem   = best_rem_reg;
    assign best_arr   = best_arr_reg;
    assign best_burst = best_burst_reg;

endmodule

[rtl/shortest_remaining_time_scheduler.sv]
// Preemptive shortest-remaining-time scheduler. A load item (func 0) writes one job entry
// and produces no result. A tick item (func 1) produces one result and occupies the block
// until it is done: the job memory has one read port and the tick walks the active entries
// (the job count, clamped to the table size) through it one per cycle, then passes through
// the states for the last compare, the write-back, the waiting-time subtract and the result.
// A tick that arrives when every active job is done goes straight to the result state. The
// result sits in an output register, so the next item is taken while it waits. No clearing
// pass follows reset.
module shortest_remaining_time_scheduler import srtf_pkg::*; #(
    parameter int MAX_JOBS  = MAX_JOBS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_count_we,
    input  logic [JOB_COUNT_W-1:0] job_count_wdata,
    srtf_in_if.sink                cmd,
    srtf_out_if.source             result
);

    localparam int IDX_W   = $clog2(MAX_JOBS);
    localparam int CNT_W   = $clog2(MAX_JOBS + 1);
    localparam int ENTRY_W = 3 * TIME_BITS;
    localparam int CMP_W   = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

    srtf_state_t state_reg, state_next;

    logic [JOB_COUNT_W-1:0] job_count_reg;
    logic [CNT_W-1:0]       active_n;
    logic [MAX_JOBS-1:0]    active_mask;
    logic [MAX_JOBS-1:0]    busy_reg;
    logic                   all_done;

    logic [IDX_W-1:0] scan_addr_reg, scan_addr_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_vld_reg;

    logic [NOW_W-1:0] now_reg;
    logic [NOW_W-1:0] now_inc;
    logic [NOW_W-1:0] tat_reg;
    logic [NOW_W-1:0] wt_reg;
    logic             fin_reg;
    logic [CMP_W-1:0] tat_diff;
    logic [CMP_W-1:0] wt_diff;
    logic [SUM_W-1:0] sum_wait_reg;
    logic [SUM_W-1:0] sum_tat_reg;
    logic [SUM_W:0]   wait_add;
    logic [SUM_W:0]   tat_add;
    logic [SUM_W-1:0] sum_wait_next;
    logic [SUM_W-1:0] sum_tat_next;

    logic cmd_ready;
    logic cmd_accept;
    logic leave;
    logic is_load;
    logic load_ok;

    logic [IDX_W+FIELD_IDX_W-1:0]      load_idx_ext;
    logic [TIME_BITS+FIELD_TIME_W-1:0] load_arr_ext;
    logic [TIME_BITS+FIELD_TIME_W-1:0] load_burst_ext;
    logic [IDX_W-1:0]                  load_addr;
    logic [TIME_BITS-1:0]              load_arr;
    logic [TIME_BITS-1:0]              load_burst;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;

    pick_ctrl_t           pick_ctrl;
    logic                 best_vld;
    logic [IDX_W-1:0]     best_idx;
    logic [TIME_BITS-1:0] best_rem;
    logic [TIME_BITS-1:0] best_arr;
    logic [TIME_BITS-1:0] best_burst;
    logic                 best_last;
    logic [IDX_W+FIELD_IDX_W-1:0] best_idx_ext;

    logic                   out_vld_reg;
    logic                   out_ran_reg;
    logic [FIELD_IDX_W-1:0] out_idx_reg;
    logic                   out_fin_reg;
    logic [NOW_W-1:0]       out_comp_reg;
    logic [NOW_W-1:0]       out_tat_reg;
    logic [NOW_W-1:0]       out_wt_reg;
    logic                   out_all_reg;
    logic [SUM_W-1:0]       out_twait_reg;
    logic [SUM_W-1:0]       out_ttat_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_count_reg <= JOB_COUNT_RESET;
        end
        else if (job_count_we)
        begin
            job_count_reg <= job_count_wdata;
        end
    end

    // Clamp the job count to the table and mark the entries in use
    assign active_n = (int'(job_count_reg) > MAX_JOBS) ? CNT_W'(MAX_JOBS)
                                                        : CNT_W'(job_count_reg);

    for (genvar g = 0; g < MAX_JOBS; g++)
    begin : g_active
        assign active_mask[g] = (g < int'(active_n));
    end

    assign all_done = ~|(busy_reg & active_mask);

    // Decode a load item
    assign cmd_accept     = cmd.valid && cmd_ready;
    assign is_load        = cmd_accept && (cmd.func == FUNC_LOAD);
    assign load_ok        = int'(cmd.job_index) < MAX_JOBS;
    assign load_idx_ext   = {{IDX_W{1'b0}}, cmd.job_index};
    assign load_arr_ext   = {{TIME_BITS{1'b0}}, cmd.job_arrival};
    assign load_burst_ext = {{TIME_BITS{1'b0}}, cmd.job_burst};
    assign load_addr      = load_idx_ext[IDX_W-1:0];
    assign load_arr       = load_arr_ext[TIME_BITS-1:0];
    assign load_burst     = load_burst_ext[TIME_BITS-1:0];

    assign best_last = best_vld && (best_rem == TIME_BITS'(1));

    // Memory write: a load in idle, or the served entry's write-back
    always_comb
    begin
        if (state_reg == ST_UPDATE)
        begin
            mem_we    = best_vld;
            mem_waddr = best_idx;
            mem_wdata = {best_arr, best_burst, best_rem - TIME_BITS'(1)};
        end
        else
        begin
            mem_we    = is_load && load_ok;
            mem_waddr = load_addr;
            mem_wdata = {load_arr, load_burst, load_burst};
        end
    end

    srtf_job_mem #(
        .DEPTH  (MAX_JOBS),
        .DATA_W (ENTRY_W)
    ) u_job_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (scan_addr_reg),
        .rdata (mem_rdata)
    );

    srtf_pick #(
        .TIME_BITS (TIME_BITS),
        .IDX_W     (IDX_W)
    ) u_pick (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (pick_ctrl),
        .rd_idx     (rd_idx_reg),
        .rd_busy    (busy_reg[rd_idx_reg]),
        .rd_arr     (mem_rdata[ENTRY_W-1 -: TIME_BITS]),
        .rd_burst   (mem_rdata[2*TIME_BITS-1 -: TIME_BITS]),
        .rd_rem     (mem_rdata[TIME_BITS-1:0]),
        .now        (now_reg),
        .best_vld   (best_vld),
        .best_idx   (best_idx),
        .best_rem   (best_rem),
        .best_arr   (best_arr),
        .best_burst (best_burst)
    );

    // Unfinished flag per entry: set by a nonzero load, cleared by a zero load or on completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else if (is_load && load_ok)
        begin
            busy_reg[load_addr] <= |load_burst;
        end
        else if ((state_reg == ST_UPDATE) && best_last)
        begin
            busy_reg[best_idx] <= 1'b0;
        end
    end

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_addr_reg <= scan_addr_next;
            rd_vld_reg    <= (state_reg == ST_SCAN);
            rd_idx_reg    <= scan_addr_reg;
        end
    end

    // Sequencer next state and controls
    always_comb
    begin
        state_next     = state_reg;
        scan_addr_next = scan_addr_reg;
        pick_ctrl      = '0;
        cmd_ready      = 1'b0;
        leave          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd.valid && (cmd.func == FUNC_TICK))
                begin
                    pick_ctrl.clear = 1'b1;
                    scan_addr_next  = '0;
                    state_next      = all_done ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                pick_ctrl.compare = rd_vld_reg;
                if ((CNT_W'(scan_addr_reg) + CNT_W'(1)) == active_n)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + IDX_W'(1);
                end
            end
            ST_LAST:
            begin
                pick_ctrl.compare = 1'b1;
                state_next        = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_vld_reg || result.ready)
                begin
                    leave      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cmd.ready = cmd_ready;

    // Time arithmetic
    assign now_inc  = (now_reg == NOW_MAX) ? now_reg : now_reg + NOW_W'(1);
    assign tat_diff = CMP_W'(now_inc) - CMP_W'(best_arr);
    assign wt_diff  = CMP_W'(tat_reg) - CMP_W'(best_burst);

    // Advance time, compute turnaround and waiting of a finishing job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
            tat_reg <= '0;
            wt_reg  <= '0;
            fin_reg <= 1'b0;
        end
        else if (cmd_accept && (cmd.func == FUNC_TICK))
        begin
            tat_reg <= '0;
            wt_reg  <= '0;
            fin_reg <= 1'b0;
        end
        else if (state_reg == ST_UPDATE)
        begin
            now_reg <= now_inc;
            fin_reg <= best_last;
            tat_reg <= best_last ? tat_diff[NOW_W-1:0] : '0;
        end
        else if (state_reg == ST_ACCUM)
        begin
            wt_reg <= (CMP_W'(tat_reg) > CMP_W'(best_burst)) ? wt_diff[NOW_W-1:0] : '0;
        end
    end

    // Saturating running totals
    assign wait_add      = {1'b0, sum_wait_reg} + (SUM_W + 1)'(wt_reg);
    assign tat_add       = {1'b0, sum_tat_reg} + (SUM_W + 1)'(tat_reg);
    assign sum_wait_next = wait_add[SUM_W] ? SUM_MAX : wait_add[SUM_W-1:0];
    assign sum_tat_next  = tat_add[SUM_W] ? SUM_MAX : tat_add[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_wait_reg <= '0;
            sum_tat_reg  <= '0;
        end
        else if (leave)
        begin
            sum_wait_reg <= sum_wait_next;
            sum_tat_reg  <= sum_tat_next;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (leave)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    assign best_idx_ext = {{FIELD_IDX_W{1'b0}}, best_idx};

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (leave)
        begin
            out_ran_reg   <= best_vld;
            out_idx_reg   <= best_vld ? best_idx_ext[FIELD_IDX_W-1:0] : '0;
            out_fin_reg   <= fin_reg;
            out_comp_reg  <= now_reg;
            out_tat_reg   <= tat_reg;
            out_wt_reg    <= wt_reg;
            out_all_reg   <= all_done;
            out_twait_reg <= sum_wait_next;
            out_ttat_reg  <= sum_tat_next;
        end
    end

    assign result.valid            = out_vld_reg;
    assign result.ran_valid        = out_ran_reg;
    assign result.ran_index        = out_idx_reg;
    assign result.finished         = out_fin_reg;
    assign result.completion_time  = out_comp_reg;
    assign result.turnaround       = out_tat_reg;
    assign result.waiting          = out_wt_reg;
    assign result.all_done         = out_all_reg;
    assign result.total_waiting    = out_twait_reg;
    assign result.total_turnaround = out_ttat_reg;

    // Time never runs backward
    a_now_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        now_reg >= $past(now_reg))
        else $error("scheduler time decreased");

    // Totals never shrink
    a_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_tat_reg >= $past(sum_tat_reg)) && (sum_wait_reg >= $past(sum_wait_reg)))
        else $error("running totals decreased");

    // A job served on its last unit of time leaves the unfinished set
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_UPDATE) && best_last) |=> !busy_reg[$past(best_idx)])
        else $error("finished job still marked unfinished");

    // A completion is only reported for a served job, with waiting within turnaround
    a_finish_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.finished) |->
            (result.ran_valid && (result.waiting <= result.turnaround)))
        else $error("inconsistent completion result");

endmodule

[dv/testbench.sv]
module testbench;
    import srtf_pkg::*;

    localparam int NJOBS            = MAX_JOBS_DEF;
    localparam int SETTLE_CYCLES    = 32;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 2000000;
    localparam int RANDOM_ITEMS     = 950;
    localparam int STEADY_ITEMS     = 150;
    localparam int RETIRE_SLACK     = 24;
    localparam int DRAIN_GUARD      = 2000;

    typedef struct packed
    {
        func_t                   func;
        logic [FIELD_IDX_W-1:0]  job_index;
        logic [FIELD_TIME_W-1:0] job_arrival;
        logic [FIELD_TIME_W-1:0] job_burst;
    } sched_cmd_t;

    typedef struct packed
    {
        logic                   ran_valid;
        logic [FIELD_IDX_W-1:0] ran_index;
        logic                   finished;
        logic [NOW_W-1:0]       completion_time;
        logic [NOW_W-1:0]       turnaround;
        logic [NOW_W-1:0]       waiting;
        logic                   all_done;
        logic [SUM_W-1:0]       total_waiting;
        logic [SUM_W-1:0]       total_turnaround;
    } tick_report_t;

    logic                   clk             = 1'b0;
    logic                   rst_n           = 1'b0;
    logic                   job_count_we    = 1'b0;
    logic [JOB_COUNT_W-1:0] job_count_wdata = '0;

    srtf_in_if  cmd_if ();
    srtf_out_if res_if ();

    shortest_remaining_time_scheduler u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_count_we    (job_count_we),
        .job_count_wdata (job_count_wdata),
        .cmd             (cmd_if),
        .result          (res_if)
    );

    // Mirror of the job table, clock and totals
    logic [FIELD_TIME_W-1:0] model_arrival   [NJOBS];
    logic [FIELD_TIME_W-1:0] model_burst     [NJOBS];
    logic [FIELD_TIME_W-1:0] model_remaining [NJOBS];
    logic [NOW_W-1:0]        model_now;
    logic [SUM_W-1:0]        model_sum_waiting;
    logic [SUM_W-1:0]        model_sum_turnaround;
    logic [JOB_COUNT_W-1:0]  model_job_count;

    tick_report_t pending_reports [$];

    bit          idle_on            = 1'b1;
    bit          long_hold_req      = 1'b0;
    int unsigned cycle_count        = 0;
    int unsigned mismatch_count     = 0;
    int unsigned report_count       = 0;
    int unsigned load_count         = 0;
    int unsigned tick_count         = 0;
    int unsigned completion_count   = 0;
    int unsigned config_write_count = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Entries below the clamped job count take part in scheduling
    function automatic int active_jobs();
        return (model_job_count > NJOBS) ? NJOBS : int'(model_job_count);
    endfunction

    function automatic bit all_jobs_done();
        int n;
        int i;
        n = active_jobs();
        for (i = 0; i < n; i++)
            if (model_remaining[i] != '0)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void apply_job_load(input sched_cmd_t item);
        model_arrival[item.job_index]   = item.job_arrival;
        model_burst[item.job_index]     = item.job_burst;
        model_remaining[item.job_index] = item.job_burst;
    endfunction

    // Serve one tick and return what the block should report for it
    function automatic tick_report_t predict_tick();
        tick_report_t     rep;
        int               pick;
        int               n;
        int               i;
        logic [FIELD_TIME_W-1:0] best;
        logic [NOW_W-1:0] arr_w;
        logic [NOW_W-1:0] burst_w;
        logic [NOW_W-1:0] tat;
        logic [NOW_W-1:0] wt;
        logic [SUM_W:0]   sum;
        rep  = '0;
        pick = -1;
        best = '0;
        if (!all_jobs_done())
        begin
            n = active_jobs();
            // Only a strictly shorter job displaces the pick, so the lowest index wins ties
            for (i = 0; i < n; i++)
            begin
                arr_w = NOW_W'(model_arrival[i]);
                if (model_remaining[i] != '0 && arr_w <= model_now &&
                    (pick < 0 || model_remaining[i] < best))
                begin
                    best = model_remaining[i];
                    pick = i;
                end
            end
            if (model_now != NOW_MAX)
                model_now = model_now + NOW_W'(1);
            if (pick >= 0)
            begin
                rep.ran_valid = 1'b1;
                rep.ran_index = pick[FIELD_IDX_W-1:0];
                model_remaining[pick] = model_remaining[pick] - FIELD_TIME_W'(1);
                if (model_remaining[pick] == '0)
                begin
                    arr_w   = NOW_W'(model_arrival[pick]);
                    burst_w = NOW_W'(model_burst[pick]);
                    tat     = model_now - arr_w;
                    wt      = (tat > burst_w) ? tat - burst_w : '0;
                    rep.finished   = 1'b1;
                    rep.turnaround = tat;
                    rep.waiting    = wt;
                    // Saturate both totals at all ones
                    sum = (SUM_W + 1)'(model_sum_waiting) + (SUM_W + 1)'(wt);
                    model_sum_waiting = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
                    sum = (SUM_W + 1)'(model_sum_turnaround) + (SUM_W + 1)'(tat);
                    model_sum_turnaround = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
                end
            end
        end
        rep.completion_time  = model_now;
        rep.all_done         = all_jobs_done();
        rep.total_waiting    = model_sum_waiting;
        rep.total_turnaround = model_sum_turnaround;
        return rep;
    endfunction

    // Offer one item, wait for the handshake, then update the mirror
    task automatic send_item(input sched_cmd_t item);
        tick_report_t report;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.func        <= item.func;
        cmd_if.job_index   <= item.job_index;
        cmd_if.job_arrival <= item.job_arrival;
        cmd_if.job_burst   <= item.job_burst;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        if (item.func == FUNC_LOAD)
        begin
            apply_job_load(item);
            load_count++;
        end
        else
        begin
            report = predict_tick();
            if (report.finished)
                completion_count++;
            pending_reports.push_back(report);
            tick_count++;
        end
        @(negedge clk);
    endtask

    task automatic load_job(input logic [FIELD_IDX_W-1:0] idx,
                            input logic [FIELD_TIME_W-1:0] arrival,
                            input logic [FIELD_TIME_W-1:0] burst);
        sched_cmd_t item;
        item.func        = FUNC_LOAD;
        item.job_index   = idx;
        item.job_arrival = arrival;
        item.job_burst   = burst;
        send_item(item);
    endtask

    task automatic tick();
        sched_cmd_t item;
        item             = '0;
        item.func        = FUNC_TICK;
        item.job_index   = FIELD_IDX_W'($urandom_range(0, NJOBS - 1));
        item.job_arrival = FIELD_TIME_W'($urandom);
        item.job_burst   = FIELD_TIME_W'($urandom);
        send_item(item);
    endtask

    task automatic tick_until_done();
        int guard;
        guard = 0;
        while (!all_jobs_done() && guard < DRAIN_GUARD)
        begin
            tick();
            guard++;
        end
    endtask

    // Drop valid and hold until every pending report is back
    task automatic wait_for_reports(input bit settle);
        cmd_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_reports.size() != 0);
        if (settle)
            repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_job_count(input logic [JOB_COUNT_W-1:0] value);
        job_count_we    <= 1'b1;
        job_count_wdata <= value;
        @(negedge clk);
        job_count_we    <= 1'b0;
        model_job_count  = value;
        config_write_count++;
    endtask

    // Shorten jobs that are long or far in the future so the table can drain
    task automatic retire_stale_jobs();
        int i;
        for (i = 0; i < NJOBS; i++)
            if (model_remaining[i] != '0 &&
                (model_remaining[i] > RETIRE_SLACK ||
                 int'(model_arrival[i]) > int'(model_now) + RETIRE_SLACK))
                load_job(i[FIELD_IDX_W-1:0], '0, FIELD_TIME_W'($urandom_range(1, 4)));
    endtask

    // Mostly ticks and short jobs arriving near now, some full-range noise loads
    function automatic sched_cmd_t random_item();
        sched_cmd_t item;
        int         n;
        int         roll;
        int         arr;
        n    = active_jobs();
        roll = $urandom_range(0, 99);
        item.func        = FUNC_LOAD;
        item.job_index   = FIELD_IDX_W'($urandom_range(0, NJOBS - 1));
        item.job_arrival = FIELD_TIME_W'($urandom);
        item.job_burst   = FIELD_TIME_W'($urandom_range(1, 16'hFFFF));
        if (roll < 75)
            item.func = FUNC_TICK;
        else if (roll < 95)
        begin
            if (n > 0 && $urandom_range(0, 4) != 0)
                item.job_index = FIELD_IDX_W'($urandom_range(0, n - 1));
            arr = int'(model_now) - 3 + int'($urandom_range(0, 10));
            if (arr < 0)
                arr = 0;
            if (arr > 16'hFFFF)
                arr = 16'hFFFF;
            item.job_arrival = arr[FIELD_TIME_W-1:0];
            item.job_burst   = FIELD_TIME_W'($urandom_range(1, 6));
        end
        return item;
    endfunction

    task automatic test_empty_table();
        tick();
    endtask

    task automatic test_preemption_and_reload();
        load_job(0, 0, 3);
        load_job(15, 0, 1);
        load_job(1, 2, 2);
        load_job(2, 16'hFFFF, 16'hFFFF);
        // A zero burst is loaded as already done
        load_job(3, 0, 0);
        repeat (3) tick();
        // Restart a running job and pull the far job in
        load_job(0, 0, 2);
        load_job(2, 0, 1);
        tick_until_done();
        tick();
    endtask

    task automatic test_job_count_extremes();
        wait_for_reports(1'b1);
        write_job_count(0);
        load_job(4, 0, 2);
        tick();
        wait_for_reports(1'b1);
        // Above the table size clamps to sixteen
        write_job_count(5'd31);
        tick_until_done();
        wait_for_reports(1'b1);
        write_job_count(1);
        // Stored above the count but not scheduled yet
        load_job(5, 0, 1);
        load_job(0, 0, 2);
        tick_until_done();
        tick();
        wait_for_reports(1'b1);
        write_job_count(JOB_COUNT_RESET);
        tick_until_done();
    endtask

    task automatic test_random_traffic();
        int unsigned            start;
        int                     phase_len;
        logic [JOB_COUNT_W-1:0] count;
        start = load_count + tick_count;
        while (load_count + tick_count - start < RANDOM_ITEMS)
        begin
            retire_stale_jobs();
            tick_until_done();
            wait_for_reports(1'b1);
            case ($urandom_range(0, 9))
                0:       count = 1;
                1:       count = JOB_COUNT_RESET;
                2:       count = 0;
                3:       count = JOB_COUNT_W'($urandom_range(17, 31));
                default: count = JOB_COUNT_W'($urandom_range(2, 15));
            endcase
            write_job_count(count);
            idle_on   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(60, 160);
            repeat (phase_len)
            begin
                send_item(random_item());
            end
        end
        retire_stale_jobs();
        tick_until_done();
        wait_for_reports(1'b1);
        idle_on = 1'b1;
        write_job_count(JOB_COUNT_RESET);
    endtask

    // Hold off results long enough for the block to stop taking items
    task automatic test_backpressure();
        load_job(0, 0, 5);
        load_job(1, 0, 3);
        load_job(7, 0, 3);
        long_hold_req = 1'b1;
        repeat (12) tick();
        tick_until_done();
    endtask

    task automatic test_sender_pause();
        load_job(2, 0, 4);
        load_job(9, 0, 2);
        repeat (3) tick();
        wait_for_reports(1'b0);
        repeat (20) send_item(random_item());
        retire_stale_jobs();
        tick_until_done();
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        repeat (STEADY_ITEMS) send_item(random_item());
    endtask

    initial
    begin : stimulus
        int i;
        cmd_if.valid       = 1'b0;
        cmd_if.func        = FUNC_LOAD;
        cmd_if.job_index   = '0;
        cmd_if.job_arrival = '0;
        cmd_if.job_burst   = '0;
        for (i = 0; i < NJOBS; i++)
        begin
            model_arrival[i]   = '0;
            model_burst[i]     = '0;
            model_remaining[i] = '0;
        end
        model_now            = '0;
        model_sum_waiting    = '0;
        model_sum_turnaround = '0;
        model_job_count      = JOB_COUNT_RESET;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_table();
        test_preemption_and_reload();
        test_job_count_extremes();
        test_random_traffic();
        test_backpressure();
        test_sender_pause();
        test_steady_stream();
        wait_for_reports(1'b1);

        $display("Run covered %0d loads and %0d ticks, %0d jobs completed, %0d job_count writes.",
                 load_count, tick_count, completion_count, config_write_count);
        $display("Compared %0d reports, %0d field mismatches, %0d still pending.",
                 report_count, mismatch_count, pending_reports.size());
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold on request
    initial
    begin : result_sink
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge clk);
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name,
                                        input logic [SUM_W-1:0] want,
                                        input logic [SUM_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each accepted report with the oldest pending one
    always @(posedge clk)
    begin : score_reports
        tick_report_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("report arrived with no tick pending");
                mismatch_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                report_count++;
                check_field("ran_valid", want.ran_valid, res_if.ran_valid);
                check_field("ran_index", want.ran_index, res_if.ran_index);
                check_field("finished", want.finished, res_if.finished);
                check_field("completion_time", want.completion_time, res_if.completion_time);
                check_field("turnaround", want.turnaround, res_if.turnaround);
                check_field("waiting", want.waiting, res_if.waiting);
                check_field("all_done", want.all_done, res_if.all_done);
                check_field("total_waiting", want.total_waiting, res_if.total_waiting);
                check_field("total_turnaround", want.total_turnaround,
                            res_if.total_turnaround);
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule
